[rtl/core/rbcr_pkg.sv]
// ----------------------------------------------------------------------------
// rbcr_pkg
// Shared constants, types and the contact microprogram of the contact resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package rbcr_pkg;

  // Body count must be a power of two (indices wrap on the low bits).
  localparam int MAX_BODIES    = 64;
  localparam int FRACTION_BITS = 16;
  localparam int BODY_BITS     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int SLOT_BITS     = 5;
  localparam int IDX_W         = (BODY_BITS > SLOT_BITS) ? BODY_BITS : SLOT_BITS;
  localparam int SEL_W         = 4;
  localparam int ADDR_W        = SEL_W + IDX_W;
  // Nine attribute regions plus one scratch region.
  localparam int DEPTH         = 10 * (1 << IDX_W);

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRACTION_BITS;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam logic [1:0] MODE_WR = 2'd0;
  localparam logic [1:0] MODE_RD = 2'd1;
  localparam logic [1:0] MODE_CT = 2'd2;

  localparam logic [3:0] AT_LX = 4'd0;
  localparam logic [3:0] AT_LY = 4'd1;
  localparam logic [3:0] AT_VX = 4'd2;
  localparam logic [3:0] AT_VY = 4'd3;
  localparam logic [3:0] AT_W  = 4'd4;
  localparam logic [3:0] AT_IM = 4'd5;
  localparam logic [3:0] AT_II = 4'd6;
  localparam logic [3:0] AT_RE = 4'd7;
  localparam logic [3:0] AT_FR = 4'd8;
  localparam logic [3:0] NUM_ATTR    = 4'd9;
  localparam logic [3:0] SEL_SCRATCH = 4'd9;

  localparam logic [4:0] IN_NX    = 5'd0;
  localparam logic [4:0] IN_NY    = 5'd1;
  localparam logic [4:0] IN_DEPTH = 5'd2;
  localparam logic [4:0] IN_SX    = 5'd3;
  localparam logic [4:0] IN_SY    = 5'd4;
  localparam logic [4:0] IN_EX    = 5'd5;
  localparam logic [4:0] IN_EY    = 5'd6;

  localparam logic [4:0] SL_BASE = 5'd0;
  localparam logic [4:0] SL_T0   = 5'd1;
  localparam logic [4:0] SL_T1   = 5'd2;
  localparam logic [4:0] SL_T2   = 5'd3;
  localparam logic [4:0] SL_DA   = 5'd4;
  localparam logic [4:0] SL_DB   = 5'd5;
  localparam logic [4:0] SL_LAX  = 5'd6;
  localparam logic [4:0] SL_LAY  = 5'd7;
  localparam logic [4:0] SL_LBX  = 5'd8;
  localparam logic [4:0] SL_LBY  = 5'd9;
  localparam logic [4:0] SL_RAX  = 5'd10;
  localparam logic [4:0] SL_RAY  = 5'd11;
  localparam logic [4:0] SL_RBX  = 5'd12;
  localparam logic [4:0] SL_RBY  = 5'd13;
  localparam logic [4:0] SL_VRX  = 5'd14;
  localparam logic [4:0] SL_VRY  = 5'd15;
  localparam logic [4:0] SL_E    = 5'd16;
  localparam logic [4:0] SL_F    = 5'd17;
  localparam logic [4:0] SL_OPE  = 5'd18;
  localparam logic [4:0] SL_C    = 5'd19;
  localparam logic [4:0] SL_DEN  = 5'd20;
  localparam logic [4:0] SL_NOPE = 5'd21;
  localparam logic [4:0] SL_TX   = 5'd22;
  localparam logic [4:0] SL_JN   = 5'd23;
  localparam logic [4:0] SL_JT   = 5'd24;
  localparam logic [4:0] SL_JX   = 5'd25;
  localparam logic [4:0] SL_JY   = 5'd26;

  localparam logic [6:0] PC_LAST = 7'd97;

  typedef enum logic [2:0] {SRC_ZERO, SRC_ONE, SRC_IN, SRC_A, SRC_B, SRC_S} src_t;
  typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MIN} op_t;

  typedef struct packed {
    src_t       kind;
    logic [4:0] sel;
  } opnd_t;

  typedef struct packed {
    op_t   op;
    opnd_t a;
    opnd_t b;
    opnd_t d;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WR, ST_RDA, ST_RDV, ST_CHK, ST_CHKV,
    ST_ISSUE, ST_EXEC, ST_DIVW, ST_WB, ST_FIN
  } st_t;

  localparam opnd_t ZR = '{kind: SRC_ZERO, sel: 5'd0};
  localparam opnd_t ON = '{kind: SRC_ONE,  sel: 5'd0};

  function automatic opnd_t fa(logic [3:0] at);
    return '{kind: SRC_A, sel: {1'b0, at}};
  endfunction

  function automatic opnd_t fb(logic [3:0] at);
    return '{kind: SRC_B, sel: {1'b0, at}};
  endfunction

  function automatic opnd_t fs(logic [4:0] sl);
    return '{kind: SRC_S, sel: sl};
  endfunction

  function automatic opnd_t fi(logic [4:0] k);
    return '{kind: SRC_IN, sel: k};
  endfunction

  function automatic uop_t mk(op_t o, opnd_t a, opnd_t b, opnd_t d);
    return '{op: o, a: a, b: b, d: d};
  endfunction

  // Contact resolution, one saturating operation per step, in model order.
  function automatic uop_t ucode(logic [6:0] pc);
    uop_t u;
    u = mk(OP_ADD, ZR, ZR, fs(SL_T0));
    unique case (pc)
      7'd0:  u = mk(OP_ADD, fa(AT_IM), fb(AT_IM), fs(SL_BASE));
      7'd1:  u = mk(OP_DIV, fi(IN_DEPTH), fs(SL_BASE), fs(SL_T0));
      7'd2:  u = mk(OP_MUL, fa(AT_IM), fs(SL_T0), fs(SL_DA));
      7'd3:  u = mk(OP_MUL, fb(AT_IM), fs(SL_T0), fs(SL_DB));
      7'd4:  u = mk(OP_ADD, fa(AT_LX), ZR, fs(SL_LAX));
      7'd5:  u = mk(OP_ADD, fa(AT_LY), ZR, fs(SL_LAY));
      7'd6:  u = mk(OP_ADD, fb(AT_LX), ZR, fs(SL_LBX));
      7'd7:  u = mk(OP_ADD, fb(AT_LY), ZR, fs(SL_LBY));
      7'd8:  u = mk(OP_MUL, fi(IN_NX), fs(SL_DA), fs(SL_T0));
      7'd9:  u = mk(OP_SUB, fs(SL_LAX), fs(SL_T0), fa(AT_LX));
      7'd10: u = mk(OP_MUL, fi(IN_NY), fs(SL_DA), fs(SL_T0));
      7'd11: u = mk(OP_SUB, fs(SL_LAY), fs(SL_T0), fa(AT_LY));
      7'd12: u = mk(OP_MUL, fi(IN_NX), fs(SL_DB), fs(SL_T0));
      7'd13: u = mk(OP_ADD, fs(SL_LBX), fs(SL_T0), fb(AT_LX));
      7'd14: u = mk(OP_MUL, fi(IN_NY), fs(SL_DB), fs(SL_T0));
      7'd15: u = mk(OP_ADD, fs(SL_LBY), fs(SL_T0), fb(AT_LY));
      7'd16: u = mk(OP_SUB, fi(IN_EX), fa(AT_LX), fs(SL_RAX));
      7'd17: u = mk(OP_SUB, fi(IN_EY), fa(AT_LY), fs(SL_RAY));
      7'd18: u = mk(OP_SUB, fi(IN_SX), fb(AT_LX), fs(SL_RBX));
      7'd19: u = mk(OP_SUB, fi(IN_SY), fb(AT_LY), fs(SL_RBY));
      7'd20: u = mk(OP_MUL, fa(AT_W), fs(SL_RAY), fs(SL_T0));
      7'd21: u = mk(OP_SUB, ZR, fs(SL_T0), fs(SL_T0));
      7'd22: u = mk(OP_ADD, fa(AT_VX), fs(SL_T0), fs(SL_T1));
      7'd23: u = mk(OP_MUL, fb(AT_W), fs(SL_RBY), fs(SL_T0));
      7'd24: u = mk(OP_SUB, ZR, fs(SL_T0), fs(SL_T0));
      7'd25: u = mk(OP_ADD, fb(AT_VX), fs(SL_T0), fs(SL_T2));
      7'd26: u = mk(OP_SUB, fs(SL_T1), fs(SL_T2), fs(SL_VRX));
      7'd27: u = mk(OP_MUL, fa(AT_W), fs(SL_RAX), fs(SL_T0));
      7'd28: u = mk(OP_ADD, fa(AT_VY), fs(SL_T0), fs(SL_T1));
      7'd29: u = mk(OP_MUL, fb(AT_W), fs(SL_RBX), fs(SL_T0));
      7'd30: u = mk(OP_ADD, fb(AT_VY), fs(SL_T0), fs(SL_T2));
      7'd31: u = mk(OP_SUB, fs(SL_T1), fs(SL_T2), fs(SL_VRY));
      7'd32: u = mk(OP_MIN, fa(AT_RE), fb(AT_RE), fs(SL_E));
      7'd33: u = mk(OP_MIN, fa(AT_FR), fb(AT_FR), fs(SL_F));
      7'd34: u = mk(OP_ADD, ON, fs(SL_E), fs(SL_OPE));
      // normal denominator
      7'd35: u = mk(OP_MUL, fs(SL_RAX), fi(IN_NY), fs(SL_T0));
      7'd36: u = mk(OP_MUL, fs(SL_RAY), fi(IN_NX), fs(SL_T1));
      7'd37: u = mk(OP_SUB, fs(SL_T0), fs(SL_T1), fs(SL_C));
      7'd38: u = mk(OP_MUL, fs(SL_C), fs(SL_C), fs(SL_T0));
      7'd39: u = mk(OP_MUL, fs(SL_T0), fa(AT_II), fs(SL_T0));
      7'd40: u = mk(OP_ADD, fs(SL_BASE), fs(SL_T0), fs(SL_DEN));
      7'd41: u = mk(OP_MUL, fs(SL_RBX), fi(IN_NY), fs(SL_T0));
      7'd42: u = mk(OP_MUL, fs(SL_RBY), fi(IN_NX), fs(SL_T1));
      7'd43: u = mk(OP_SUB, fs(SL_T0), fs(SL_T1), fs(SL_C));
      7'd44: u = mk(OP_MUL, fs(SL_C), fs(SL_C), fs(SL_T0));
      7'd45: u = mk(OP_MUL, fs(SL_T0), fb(AT_II), fs(SL_T0));
      7'd46: u = mk(OP_ADD, fs(SL_DEN), fs(SL_T0), fs(SL_DEN));
      7'd47: u = mk(OP_SUB, ZR, fs(SL_OPE), fs(SL_NOPE));
      7'd48: u = mk(OP_MUL, fs(SL_VRX), fi(IN_NX), fs(SL_T0));
      7'd49: u = mk(OP_MUL, fs(SL_VRY), fi(IN_NY), fs(SL_T1));
      7'd50: u = mk(OP_ADD, fs(SL_T0), fs(SL_T1), fs(SL_T0));
      7'd51: u = mk(OP_MUL, fs(SL_NOPE), fs(SL_T0), fs(SL_T0));
      7'd52: u = mk(OP_DIV, fs(SL_T0), fs(SL_DEN), fs(SL_JN));
      // tangent = (-ny, nx)
      7'd53: u = mk(OP_SUB, ZR, fi(IN_NY), fs(SL_TX));
      7'd54: u = mk(OP_MUL, fs(SL_RAX), fi(IN_NX), fs(SL_T0));
      7'd55: u = mk(OP_MUL, fs(SL_RAY), fs(SL_TX), fs(SL_T1));
      7'd56: u = mk(OP_SUB, fs(SL_T0), fs(SL_T1), fs(SL_C));
      7'd57: u = mk(OP_MUL, fs(SL_C), fs(SL_C), fs(SL_T0));
      7'd58: u = mk(OP_MUL, fs(SL_T0), fa(AT_II), fs(SL_T0));
      7'd59: u = mk(OP_ADD, fs(SL_BASE), fs(SL_T0), fs(SL_DEN));
      7'd60: u = mk(OP_MUL, fs(SL_RBX), fi(IN_NX), fs(SL_T0));
      7'd61: u = mk(OP_MUL, fs(SL_RBY), fs(SL_TX), fs(SL_T1));
      7'd62: u = mk(OP_SUB, fs(SL_T0), fs(SL_T1), fs(SL_C));
      7'd63: u = mk(OP_MUL, fs(SL_C), fs(SL_C), fs(SL_T0));
      7'd64: u = mk(OP_MUL, fs(SL_T0), fb(AT_II), fs(SL_T0));
      7'd65: u = mk(OP_ADD, fs(SL_DEN), fs(SL_T0), fs(SL_DEN));
      7'd66: u = mk(OP_MUL, fs(SL_F), fs(SL_NOPE), fs(SL_T2));
      7'd67: u = mk(OP_MUL, fs(SL_VRX), fs(SL_TX), fs(SL_T0));
      7'd68: u = mk(OP_MUL, fs(SL_VRY), fi(IN_NX), fs(SL_T1));
      7'd69: u = mk(OP_ADD, fs(SL_T0), fs(SL_T1), fs(SL_T0));
      7'd70: u = mk(OP_MUL, fs(SL_T2), fs(SL_T0), fs(SL_T0));
      7'd71: u = mk(OP_DIV, fs(SL_T0), fs(SL_DEN), fs(SL_JT));
      7'd72: u = mk(OP_MUL, fi(IN_NX), fs(SL_JN), fs(SL_T0));
      7'd73: u = mk(OP_MUL, fs(SL_TX), fs(SL_JT), fs(SL_T1));
      7'd74: u = mk(OP_ADD, fs(SL_T0), fs(SL_T1), fs(SL_JX));
      7'd75: u = mk(OP_MUL, fi(IN_NY), fs(SL_JN), fs(SL_T0));
      7'd76: u = mk(OP_MUL, fi(IN_NX), fs(SL_JT), fs(SL_T1));
      7'd77: u = mk(OP_ADD, fs(SL_T0), fs(SL_T1), fs(SL_JY));
      // apply to first body
      7'd78: u = mk(OP_MUL, fs(SL_JX), fa(AT_IM), fs(SL_T0));
      7'd79: u = mk(OP_ADD, fa(AT_VX), fs(SL_T0), fa(AT_VX));
      7'd80: u = mk(OP_MUL, fs(SL_JY), fa(AT_IM), fs(SL_T0));
      7'd81: u = mk(OP_ADD, fa(AT_VY), fs(SL_T0), fa(AT_VY));
      7'd82: u = mk(OP_MUL, fs(SL_RAX), fs(SL_JY), fs(SL_T0));
      7'd83: u = mk(OP_MUL, fs(SL_RAY), fs(SL_JX), fs(SL_T1));
      7'd84: u = mk(OP_SUB, fs(SL_T0), fs(SL_T1), fs(SL_C));
      7'd85: u = mk(OP_MUL, fs(SL_C), fa(AT_II), fs(SL_T0));
      7'd86: u = mk(OP_ADD, fa(AT_W), fs(SL_T0), fa(AT_W));
      7'd87: u = mk(OP_SUB, ZR, fs(SL_JX), fs(SL_JX));
      7'd88: u = mk(OP_SUB, ZR, fs(SL_JY), fs(SL_JY));
      // apply to second body
      7'd89: u = mk(OP_MUL, fs(SL_JX), fb(AT_IM), fs(SL_T0));
      7'd90: u = mk(OP_ADD, fb(AT_VX), fs(SL_T0), fb(AT_VX));
      7'd91: u = mk(OP_MUL, fs(SL_JY), fb(AT_IM), fs(SL_T0));
      7'd92: u = mk(OP_ADD, fb(AT_VY), fs(SL_T0), fb(AT_VY));
      7'd93: u = mk(OP_MUL, fs(SL_RBX), fs(SL_JY), fs(SL_T0));
      7'd94: u = mk(OP_MUL, fs(SL_RBY), fs(SL_JX), fs(SL_T1));
      7'd95: u = mk(OP_SUB, fs(SL_T0), fs(SL_T1), fs(SL_C));
      7'd96: u = mk(OP_MUL, fs(SL_C), fb(AT_II), fs(SL_T0));
      7'd97: u = mk(OP_ADD, fb(AT_W), fs(SL_T0), fb(AT_W));
      default: u = mk(OP_ADD, ZR, ZR, fs(SL_T0));
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rigid_body_contact_resolver_unit.sv]
// ----------------------------------------------------------------------------
// rigid_body_contact_resolver_unit
// 2D rigid body table with attribute access and impulse contact resolution.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  item     | item_valid / item_stall     | mode, body_a, body_b, attribute,
//           |                             | value, normal_*, depth, start_*, end_*
//  result   | result_valid / result_stall | read_value, status
//
//  One item at a time. A write passes ST_WR, ST_FIN; a read ST_RDA,
//  ST_RDV, ST_FIN; a skipped contact ST_CHK, ST_CHKV, ST_FIN; an unknown
//  mode ST_FIN. A contact runs 98 microsteps (issue, execute, write back)
//  through the store's single write port, three of them on the divider.
//  The result register lets the next item enter while a result waits.
//  Reset clears control only; table entries are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_contact_resolver_unit
  import rbcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [5:0]  body_a,
  input  wire logic [5:0]  body_b,
  input  wire logic [3:0]  attribute,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] normal_x,
  input  wire logic signed [31:0] normal_y,
  input  wire logic signed [31:0] depth,
  input  wire logic signed [31:0] start_x,
  input  wire logic signed [31:0] start_y,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic signed [31:0] read_value,
  output logic             status
);

  st_t state, state_next;
  logic [6:0] pc;
  logic [1:0] mode_r;
  logic [BODY_BITS-1:0] ba, bb;
  logic [3:0] attr_r;
  logic signed [31:0] value_r, nx, ny, dp, sx, sy, ex, ey;
  src_t ka, kb;
  logic signed [31:0] aux_a, aux_b;
  logic signed [31:0] prod_sh;
  logic signed [63:0] prod;
  logic signed [31:0] alu;
  logic signed [31:0] rv_r;
  logic stat_r;

  logic [ADDR_W-1:0] ra_addr, rb_addr, wa;
  logic signed [31:0] ra_data, rb_data, wd;
  logic we;
  logic div_start, div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] opa, opb;
  uop_t u;
  logic take;

  function automatic logic [ADDR_W-1:0] addr_of(opnd_t o, logic [BODY_BITS-1:0] a,
                                                 logic [BODY_BITS-1:0] b);
    logic [ADDR_W-1:0] r;
    unique case (o.kind)
      SRC_A:   r = {o.sel[3:0], IDX_W'(a)};
      SRC_B:   r = {o.sel[3:0], IDX_W'(b)};
      default: r = {SEL_SCRATCH, IDX_W'(o.sel)};
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(logic signed [32:0] x);
    return (x[32] != x[31]) ? (x[32] ? Q_MIN : Q_MAX) : x[31:0];
  endfunction

  assign u    = ucode(pc);
  assign take = item_valid && !item_stall;

  rbcr_store u_store (
    .clk     (clk),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .we      (we),
    .wa      (wa),
    .wd      (wd)
  );

  rbcr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .quot  (div_q)
  );

  // memory, scratch and input operands merge here
  assign opa = (ka == SRC_A || ka == SRC_B || ka == SRC_S) ? ra_data : aux_a;
  assign opb = (kb == SRC_A || kb == SRC_B || kb == SRC_S) ? rb_data : aux_b;

  function automatic logic signed [31:0] aux_of(opnd_t o, logic signed [31:0] i0,
      logic signed [31:0] i1, logic signed [31:0] i2, logic signed [31:0] i3,
      logic signed [31:0] i4, logic signed [31:0] i5, logic signed [31:0] i6);
    logic signed [31:0] r;
    r = 32'sd0;
    if (o.kind == SRC_ONE) begin
      r = ONE_Q;
    end else if (o.kind == SRC_IN) begin
      unique case (o.sel)
        IN_NX:    r = i0;
        IN_NY:    r = i1;
        IN_DEPTH: r = i2;
        IN_SX:    r = i3;
        IN_SY:    r = i4;
        IN_EX:    r = i5;
        IN_EY:    r = i6;
        default:  r = 32'sd0;
      endcase
    end
    return r;
  endfunction

  assign prod_sh = ((prod >>> FRACTION_BITS) > 64'sd2147483647) ? Q_MAX :
                   ((prod >>> FRACTION_BITS) < -64'sd2147483648) ? Q_MIN :
                   32'(prod >>> FRACTION_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    ra_addr    = addr_of(u.a, ba, bb);
    rb_addr    = addr_of(u.b, ba, bb);
    we         = 1'b0;
    wa         = addr_of(u.d, ba, bb);
    wd         = (u.op == OP_MUL) ? prod_sh : (u.op == OP_DIV) ? div_q : alu;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          unique case (mode)
            MODE_WR: state_next = ST_WR;
            MODE_RD: state_next = ST_RDA;
            MODE_CT: state_next = ST_CHK;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_WR: begin
        wa = {attr_r, IDX_W'(ba)};
        wd = value_r;
        we = (attr_r < NUM_ATTR);
        state_next = ST_FIN;
      end
      ST_RDA: begin
        ra_addr    = {attr_r, IDX_W'(ba)};
        state_next = ST_RDV;
      end
      ST_RDV:  state_next = ST_FIN;
      ST_CHK: begin
        ra_addr    = {AT_IM, IDX_W'(ba)};
        rb_addr    = {AT_IM, IDX_W'(bb)};
        state_next = ST_CHKV;
      end
      ST_CHKV: begin
        state_next = (ra_data == 32'sd0 && rb_data == 32'sd0) ? ST_FIN : ST_ISSUE;
      end
      ST_ISSUE: state_next = ST_EXEC;
      ST_EXEC: begin
        if (u.op == OP_DIV) begin
          div_start  = 1'b1;
          state_next = ST_DIVW;
        end else begin
          state_next = ST_WB;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        we         = 1'b1;
        state_next = (pc == PC_LAST) ? ST_FIN : ST_ISSUE;
      end
      ST_FIN: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (take) begin
      mode_r  <= mode;
      ba      <= BODY_BITS'(body_a);
      bb      <= BODY_BITS'(body_b);
      attr_r  <= attribute;
      value_r <= value;
      nx      <= normal_x;
      ny      <= normal_y;
      dp      <= depth;
      sx      <= start_x;
      sy      <= start_y;
      ex      <= end_x;
      ey      <= end_y;
      rv_r    <= 32'sd0;
      stat_r  <= 1'b0;
    end
    unique case (state)
      ST_RDV: begin
        rv_r <= (attr_r < NUM_ATTR && mode_r == MODE_RD) ? ra_data : 32'sd0;
      end
      ST_CHKV: begin
        stat_r <= (ra_data == 32'sd0 && rb_data == 32'sd0);
        pc     <= 7'd0;
      end
      ST_ISSUE: begin
        ka    <= u.a.kind;
        kb    <= u.b.kind;
        aux_a <= aux_of(u.a, nx, ny, dp, sx, sy, ex, ey);
        aux_b <= aux_of(u.b, nx, ny, dp, sx, sy, ex, ey);
      end
      ST_EXEC: begin
        prod <= 64'(opa) * 64'(opb);
        unique case (u.op)
          OP_ADD:  alu <= sat33(33'(opa) + 33'(opb));
          OP_SUB:  alu <= sat33(33'(opa) - 33'(opb));
          OP_MIN:  alu <= (opa < opb) ? opa : opb;
          default: alu <= 32'sd0;
        endcase
      end
      ST_WB: pc <= pc + 7'd1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FIN && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!result_valid || !result_stall)) begin
      read_value <= rv_r;
      status     <= stat_r;
    end
  end

endmodule

`default_nettype wire

[rtl/core/rbcr_store.sv]
// ----------------------------------------------------------------------------
// rbcr_store
// Body attribute and scratch memory: one write port, two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rbcr_store
  import rbcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [ADDR_W-1:0] ra_addr,
  input  wire logic [ADDR_W-1:0] rb_addr,
  output logic signed [31:0]     ra_data,
  output logic signed [31:0]     rb_data,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wa,
  input  wire logic signed [31:0] wd
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

[rtl/core/rbcr_div.sv]
// ----------------------------------------------------------------------------
// rbcr_div
// Fixed-point divider, one quotient bit per cycle, truncating and saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module rbcr_div
  import rbcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                   done,
  output logic signed [31:0]     quot
);

  localparam int NB = 32 + FRACTION_BITS;
  localparam int CW = $clog2(NB + 1);
  localparam logic [NB-1:0] LIM = NB'(1) << 31;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NB-1:0] dvd;
  logic [NB-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   dabs;
  logic          neg;
  logic [32:0]   sh;
  logic [32:0]   diff;
  logic [31:0]   nabs;

  assign nabs = num[31] ? 32'(-num) : 32'(num);
  assign sh   = {rem, dvd[NB-1]};
  assign diff = sh - {1'b0, dabs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (den != 32'sd0);
        done <= (den == 32'sd0);
      end else if (busy) begin
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {nabs, {FRACTION_BITS{1'b0}}};
      dabs <= den[31] ? 32'(-den) : 32'(den);
      neg  <= num[31] ^ den[31];
      rem  <= '0;
      quo  <= '0;
      cnt  <= CW'(NB);
    end else if (busy) begin
      dvd <= {dvd[NB-2:0], 1'b0};
      cnt <= cnt - CW'(1);
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[NB-2:0], 1'b1};
      end else begin
        rem <= sh[31:0];
        quo <= {quo[NB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg) begin
      quot = (quo > LIM) ? Q_MIN : 32'(-quo[31:0]);
    end else begin
      quot = (quo >= LIM) ? Q_MAX : 32'(quo[31:0]);
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rigid body contact resolver. A scoreboard keeps
// its own body table, works out the expected read value and status of every
// transfer into the block, and compares them in order with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rbcr_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam int         IDLE_LIMIT = 40000;
  localparam int         Q1         = 1 << FRACTION_BITS;

  typedef struct {
    logic [1:0] mode;
    logic [5:0] a;
    logic [5:0] b;
    logic [3:0] attr;
    int         value, nx, ny, dep, sx, sy, ex, ey;
  } body_item_t;

  typedef struct {
    int rv;
    bit st;
  } body_answer_t;

  class contact_scoreboard;
    int           tab[9][MAX_BODIES];
    body_answer_t answers[$];
    int           mismatches;

    function int sat(longint x);
      if (x > longint'(Q_MAX)) return Q_MAX;
      if (x < longint'(Q_MIN)) return Q_MIN;
      return int'(x);
    endfunction

    function int add(int x, int y); return sat(longint'(x) + longint'(y)); endfunction
    function int sub(int x, int y); return sat(longint'(x) - longint'(y)); endfunction
    function int neg(int x); return sat(-longint'(x)); endfunction
    function int mul(int x, int y);
      longint p;
      p = longint'(x) * longint'(y);
      return sat(p >>> FRACTION_BITS);
    endfunction
    function int dvd(int x, int y);
      if (y == 0) return 0;
      return sat((longint'(x) * longint'(Q1)) / longint'(y));
    endfunction
    function int crs(int ax, int ay, int bx, int by);
      return sub(mul(ax, by), mul(ay, bx));
    endfunction
    function int mn(int x, int y); return x < y ? x : y; endfunction

    function void collide(int a, int b, body_item_t it);
      int ima, imb, s, da, db, rax, ray, rbx, rby, wa, wb, vrx, vry;
      int iia, iib, e, f, ope, tx, ty, c, den, jn, jt, jx, jy, base;
      ima = tab[AT_IM][a];
      imb = tab[AT_IM][b];
      s  = dvd(it.dep, add(ima, imb));
      da = mul(ima, s);
      db = mul(imb, s);
      // read all four locations before any update: the same body may be a and b
      begin
        int lax, lay, lbx, lby;
        lax = tab[AT_LX][a]; lay = tab[AT_LY][a];
        lbx = tab[AT_LX][b]; lby = tab[AT_LY][b];
        tab[AT_LX][a] = sub(lax, mul(it.nx, da));
        tab[AT_LY][a] = sub(lay, mul(it.ny, da));
        tab[AT_LX][b] = add(lbx, mul(it.nx, db));
        tab[AT_LY][b] = add(lby, mul(it.ny, db));
      end
      rax = sub(it.ex, tab[AT_LX][a]); ray = sub(it.ey, tab[AT_LY][a]);
      rbx = sub(it.sx, tab[AT_LX][b]); rby = sub(it.sy, tab[AT_LY][b]);
      wa = tab[AT_W][a]; wb = tab[AT_W][b];
      vrx = sub(add(tab[AT_VX][a], neg(mul(wa, ray))), add(tab[AT_VX][b], neg(mul(wb, rby))));
      vry = sub(add(tab[AT_VY][a], mul(wa, rax)), add(tab[AT_VY][b], mul(wb, rbx)));
      iia = tab[AT_II][a]; iib = tab[AT_II][b];
      e = mn(tab[AT_RE][a], tab[AT_RE][b]);
      f = mn(tab[AT_FR][a], tab[AT_FR][b]);
      ope = sat(longint'(Q1) + longint'(e));
      base = add(ima, imb);
      c = crs(rax, ray, it.nx, it.ny);
      den = add(base, mul(mul(c, c), iia));
      c = crs(rbx, rby, it.nx, it.ny);
      den = add(den, mul(mul(c, c), iib));
      jn = dvd(mul(neg(ope), add(mul(vrx, it.nx), mul(vry, it.ny))), den);
      tx = neg(it.ny); ty = it.nx;
      c = crs(rax, ray, tx, ty);
      den = add(base, mul(mul(c, c), iia));
      c = crs(rbx, rby, tx, ty);
      den = add(den, mul(mul(c, c), iib));
      jt = dvd(mul(mul(f, neg(ope)), add(mul(vrx, tx), mul(vry, ty))), den);
      jx = add(mul(it.nx, jn), mul(tx, jt));
      jy = add(mul(it.ny, jn), mul(ty, jt));
      tab[AT_VX][a] = add(tab[AT_VX][a], mul(jx, tab[AT_IM][a]));
      tab[AT_VY][a] = add(tab[AT_VY][a], mul(jy, tab[AT_IM][a]));
      tab[AT_W][a]  = add(tab[AT_W][a], mul(crs(rax, ray, jx, jy), tab[AT_II][a]));
      jx = neg(jx); jy = neg(jy);
      tab[AT_VX][b] = add(tab[AT_VX][b], mul(jx, tab[AT_IM][b]));
      tab[AT_VY][b] = add(tab[AT_VY][b], mul(jy, tab[AT_IM][b]));
      tab[AT_W][b]  = add(tab[AT_W][b], mul(crs(rbx, rby, jx, jy), tab[AT_II][b]));
    endfunction

    function void note_item(body_item_t it);
      body_answer_t ans;
      int a, b;
      a = it.a % MAX_BODIES;
      b = it.b % MAX_BODIES;
      ans.rv = 0;
      ans.st = 0;
      case (it.mode)
        MODE_WR: if (it.attr < NUM_ATTR) tab[it.attr][a] = it.value;
        MODE_RD: if (it.attr < NUM_ATTR) ans.rv = tab[it.attr][a];
        MODE_CT: begin
          if (tab[AT_IM][a] == 0 && tab[AT_IM][b] == 0) ans.st = 1;
          else collide(a, b, it);
        end
        default: ;
      endcase
      answers.push_back(ans);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_result(int rv, bit st);
      body_answer_t want;
      if (answers.size() == 0) begin
        report("unexpected result", rv, 0);
      end else begin
        want = answers.pop_front();
        if (rv != want.rv) report("read_value", rv, want.rv);
        if (st != want.st) report("status", int'(st), int'(want.st));
      end
    endtask

    function int pending();
      return answers.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  mode = MODE_WR;
  logic [5:0]  body_a = '0;
  logic [5:0]  body_b = '0;
  logic [3:0]  attribute = AT_LX;
  logic signed [31:0] value = '0, normal_x = '0, normal_y = '0, depth = '0;
  logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic signed [31:0] read_value;
  logic        status;

  contact_scoreboard sb = new();
  bit  item_taken = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;

  always #2 clk = ~clk;

  rigid_body_contact_resolver_unit DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .body_a(body_a), .body_b(body_b), .attribute(attribute),
    .value(value), .normal_x(normal_x), .normal_y(normal_y), .depth(depth),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_value(read_value), .status(status)
  );

  always @(posedge clk) begin
    body_item_t it;
    if (!rst) begin
      idle_cycles++;
      if (item_valid && !item_stall) begin
        it = '{mode, body_a, body_b, attribute, value, normal_x, normal_y, depth,
               start_x, start_y, end_x, end_y};
        sb.note_item(it);
        item_taken = 1;
        idle_cycles = 0;
      end
      if (result_valid && !result_stall) begin
        sb.check_result(read_value, status);
        idle_cycles = 0;
      end
    end
  end

  // Receiver stalls with a duty that changes every so often, zero included.
  always @(negedge clk) begin
    int level, cnt;
    if (cnt == 0) begin
      level = $urandom_range(0, 3);
      cnt = $urandom_range(20, 120);
    end
    cnt--;
    result_stall <= (level != 0) && ($urandom_range(0, 3) < level);
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL rigid_body_contact_resolver_unit");
    $finish;
  end

  // Valid stays high between transfers of a burst; drop it only for a real gap.
  task automatic send(body_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_valid <= 1'b1;
    mode <= it.mode; body_a <= it.a; body_b <= it.b; attribute <= it.attr;
    value <= it.value; normal_x <= it.nx; normal_y <= it.ny; depth <= it.dep;
    start_x <= it.sx; start_y <= it.sy; end_x <= it.ex; end_y <= it.ey;
    item_taken = 0;
    do @(negedge clk); while (!item_taken);
    item_taken = 0;
  endtask

  function automatic int rnd32();
    return int'($urandom());
  endfunction

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Physically plausible value for each attribute.
  function automatic int sane_value(logic [3:0] at, int idx);
    case (at)
      AT_LX, AT_LY: return span(-100 * Q1, 100 * Q1);
      AT_VX, AT_VY: return span(-10 * Q1, 10 * Q1);
      AT_W:         return span(-4 * Q1, 4 * Q1);
      AT_IM:        return (idx < 4) ? 0 : span(0, 2 * Q1);
      AT_II:        return span(0, Q1);
      default:      return span(0, Q1);
    endcase
  endfunction

  function automatic body_item_t wr(int b, logic [3:0] at, int v);
    body_item_t it;
    it = '{MODE_WR, 6'(b), 6'($urandom()), at, v, rnd32(), rnd32(), rnd32(),
           rnd32(), rnd32(), rnd32(), rnd32()};
    return it;
  endfunction

  function automatic body_item_t rd(int b, logic [3:0] at);
    body_item_t it;
    it = wr(b, at, rnd32());
    it.mode = MODE_RD;
    return it;
  endfunction

  function automatic body_item_t contact(int a, int b, bit wild);
    body_item_t it;
    int k, p;
    it = wr(a, 4'($urandom()), rnd32());
    it.mode = MODE_CT;
    it.b = 6'(b);
    if (!wild) begin
      k = $urandom_range(0, 7);
      p = 46341;  // about one over root two
      case (k)
        0: begin it.nx = Q1;  it.ny = 0;   end
        1: begin it.nx = -Q1; it.ny = 0;   end
        2: begin it.nx = 0;   it.ny = Q1;  end
        3: begin it.nx = 0;   it.ny = -Q1; end
        4: begin it.nx = p;   it.ny = p;   end
        5: begin it.nx = -p;  it.ny = p;   end
        default: begin it.nx = span(-Q1, Q1); it.ny = span(-Q1, Q1); end
      endcase
      it.dep = span(0, 2 * Q1);
      it.sx = span(-100 * Q1, 100 * Q1); it.sy = span(-100 * Q1, 100 * Q1);
      it.ex = span(-100 * Q1, 100 * Q1); it.ey = span(-100 * Q1, 100 * Q1);
    end
    return it;
  endfunction

  initial begin
    body_item_t it;
    int r;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // fill the whole table so no read touches an unwritten entry
    for (int b = 0; b < MAX_BODIES; b++)
      for (int at = 0; at < NUM_ATTR; at++)
        send(wr(b, 4'(at), sane_value(4'(at), b)));

    // directed: extremes, unknown codes, static pair, zero divisor, shared body
    send(wr(60, AT_VX, Q_MAX));
    send(wr(60, AT_VY, Q_MIN));
    send(rd(60, AT_VX));
    send(rd(60, AT_VY));
    send(wr(60, 4'd15, Q_MAX));
    send(rd(60, 4'd15));
    send(rd(60, NUM_ATTR));
    it = rd(61, AT_FR); it.mode = MODE_NONE; send(it);
    send(contact(0, 1, 0));
    send(contact(2, 2, 0));
    send(wr(10, AT_IM, Q1));
    send(wr(11, AT_IM, -Q1));
    send(contact(10, 11, 0));
    send(contact(12, 12, 0));
    send(contact(13, 60, 1));
    it = contact(20, 21, 0);
    it.nx = Q_MAX; it.ny = Q_MIN; it.dep = Q_MIN;
    it.sx = Q_MAX; it.sy = Q_MIN; it.ex = Q_MIN; it.ey = Q_MAX;
    send(it);
    it.nx = Q_MIN; it.ny = Q_MAX; it.dep = Q_MAX; it.a = 6'd63; it.b = 6'd0;
    send(it);
    for (int at = 0; at < NUM_ATTR; at++) send(rd(20, 4'(at)));

    // pause until the block has drained everything
    item_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);

    for (int n = 0; n < 1330; n++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        it = wr($urandom_range(0, 63), 4'($urandom_range(0, 8)), 0);
        it.value = ($urandom_range(0, 9) == 0) ? rnd32() : sane_value(it.attr, it.a);
        if ($urandom_range(0, 15) == 0) it.attr = 4'($urandom_range(9, 15));
      end else if (r < 40) begin
        it = rd($urandom_range(0, 63), 4'($urandom_range(0, 9)));
        if ($urandom_range(0, 15) == 0) it.attr = 4'($urandom_range(9, 15));
      end else if (r < 97) begin
        it = contact($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 19) == 0);
        if ($urandom_range(0, 9) == 0) it.b = it.a;
        if ($urandom_range(0, 9) == 0) begin
          it.a = 6'($urandom_range(0, 3)); it.b = 6'($urandom_range(0, 3));
        end
      end else begin
        it = rd($urandom_range(0, 63), 4'($urandom()));
        it.mode = MODE_NONE;
      end
      send(it);
    end

    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (sb.pending() != 0) sb.report("missing results", sb.pending(), 0);
    if (sb.mismatches == 0) begin
      $display("PASS rigid_body_contact_resolver_unit");
    end else begin
      $display("FAIL rigid_body_contact_resolver_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rbcr_pkg.sv
rtl/core/rbcr_store.sv
rtl/core/rbcr_div.sv
rtl/core/rigid_body_contact_resolver_unit.sv
tb/testbench.sv
